>>> rtl/stsort_pkg.sv
// Shared constants and types for the score table sorter.
package stsort_pkg;

    localparam int ENTRIES    = 16;
    localparam int NAME_BYTES = 7;

    localparam int SCORE_W = 16;
    localparam int NAME_W  = NAME_BYTES * 8;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int RANK_W  = 4;
    localparam int EXCH_W  = 7;

    localparam logic [EXCH_W-1:0] EXCH_MAX = {EXCH_W{1'b1}};
    localparam int EXCH_PAIRS = ENTRIES * (ENTRIES - 1) / 2;
    localparam int EXCH_LIMIT = (EXCH_PAIRS > 127) ? 127 : EXCH_PAIRS;

    localparam int REC_W       = SCORE_W + NAME_W;
    localparam int OUT_FIELD_W = SCORE_W + NAME_W + RANK_W + EXCH_W;
    localparam int S_TDATA_W   = ((REC_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef struct packed {
        logic [NAME_W-1:0]  name;
        logic [SCORE_W-1:0] score;
    } rec_t;

    typedef struct packed {
        logic              load;
        rec_t              rec;
        logic [RANK_W-1:0] rank;
        logic [EXCH_W-1:0] exch;
        logic              last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEEK,
        ST_PLACE,
        ST_DRAIN_RD,
        ST_DRAIN_LD
    } state_t;

endpackage

>>> rtl/stsort_ram.sv
// Generic single-write, single-read memory with registered read data.
module stsort_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/stsort_ctrl.sv
// Insertion sequencer: shifts stored records down one per cycle, then drains the table once it is full.
module stsort_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  stsort_pkg::rec_t           in_rec,
    output logic                       ram_wr_en,
    output logic [stsort_pkg::IDX_W-1:0] ram_wr_addr,
    output stsort_pkg::rec_t           ram_wr_data,
    output logic [stsort_pkg::IDX_W-1:0] ram_rd_addr,
    input  stsort_pkg::rec_t           ram_rd_data,
    input  logic                       out_free,
    output stsort_pkg::out_item_t      out_item
);
    import stsort_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [EXCH_W-1:0] exch_reg, exch_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    rec_t              new_reg, new_next;

    logic greater;
    logic full_after;
    logic k_last;

    assign greater    = new_reg.score > ram_rd_data.score;
    assign full_after = (cnt_reg + CNT_W'(1)) == CNT_W'(ENTRIES);
    assign k_last     = k_reg == IDX_W'(ENTRIES - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            exch_reg  <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            exch_reg  <= exch_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        new_reg <= new_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid && cnt_reg != '0) begin
                    state_next = ST_SEEK;
                end
            end
            ST_SEEK: begin
                if (greater && pos_reg != IDX_W'(1)) begin
                    state_next = ST_SEEK;
                end else if (greater) begin
                    state_next = ST_PLACE;
                end else if (full_after) begin
                    state_next = ST_DRAIN_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PLACE: begin
                state_next = full_after ? ST_DRAIN_RD : ST_IDLE;
            end
            ST_DRAIN_RD: begin
                state_next = ST_DRAIN_LD;
            end
            ST_DRAIN_LD: begin
                if (out_free && k_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready      = 1'b0;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = pos_reg;
        ram_wr_data   = new_reg;
        ram_rd_addr   = k_reg;
        cnt_next      = cnt_reg;
        exch_next     = exch_reg;
        pos_next      = pos_reg;
        k_next        = k_reg;
        new_next      = new_reg;
        out_item.load = 1'b0;
        out_item.rec  = ram_rd_data;
        out_item.rank = RANK_W'(k_reg);
        out_item.exch = exch_reg;
        out_item.last = k_last;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (cnt_reg == '0) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = '0;
                        ram_wr_data = in_rec;
                        cnt_next    = CNT_W'(1);
                    end else begin
                        new_next    = in_rec;
                        pos_next    = cnt_reg[IDX_W-1:0];
                        ram_rd_addr = IDX_W'(cnt_reg - CNT_W'(1));
                    end
                end
            end
            ST_SEEK: begin
                ram_wr_en = 1'b1;
                if (greater) begin
                    ram_wr_data = ram_rd_data;
                    pos_next    = pos_reg - IDX_W'(1);
                    ram_rd_addr = pos_reg - IDX_W'(2);
                    if (exch_reg != EXCH_MAX) begin
                        exch_next = exch_reg + EXCH_W'(1);
                    end
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    k_next   = '0;
                end
            end
            ST_PLACE: begin
                ram_wr_en = 1'b1;
                cnt_next  = cnt_reg + CNT_W'(1);
                k_next    = '0;
            end
            ST_DRAIN_RD: begin
                ram_rd_addr = k_reg;
            end
            ST_DRAIN_LD: begin
                if (out_free) begin
                    out_item.load = 1'b1;
                    k_next        = k_reg + IDX_W'(1);
                    ram_rd_addr   = k_reg + IDX_W'(1);
                    if (k_last) begin
                        cnt_next  = '0;
                        exch_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/score_table_sorter_top.sv
// Top level of the score table sorter: record memory, sequencer and output register.
//
// Records arrive one per item; each is inserted into a 16-entry memory kept in
// descending score order (stable for equal scores). Insertion moves stored records
// down one slot per cycle, set by the single write port of the record memory: the
// first record of a batch is written directly, every later record moves past each
// stored record with a lower score. After the 16th record the whole table streams
// out highest score first, one item per cycle when m_tready stays high, after a
// registered memory read; input is held off until the last result is registered.
// Every result carries the batch's exchange count; m_tlast marks rank 15.
module score_table_sorter_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // score [15:0], name_tag [71:16]
    input  logic [stsort_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // sorted_score [15:0], sorted_name [71:16], rank [75:72],
    // exchange_count [82:76], zero fill above
    output logic [stsort_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                               m_tlast
);
    import stsort_pkg::*;

    rec_t              in_rec;
    rec_t              ram_wr_data;
    rec_t              ram_rd_data;
    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic [IDX_W-1:0]  ram_rd_addr;
    logic              out_free;
    out_item_t         out_item;

    logic              m_valid_reg;
    rec_t              m_rec_reg;
    logic [RANK_W-1:0] m_rank_reg;
    logic [EXCH_W-1:0] m_exch_reg;
    logic              m_last_reg;

    assign in_rec.score = s_tdata[SCORE_W-1:0];
    assign in_rec.name  = s_tdata[SCORE_W+NAME_W-1:SCORE_W];

    stsort_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    stsort_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_rec      (in_rec),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .out_free    (out_free),
        .out_item    (out_item)
    );

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_item.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_item.load) begin
            m_rec_reg  <= out_item.rec;
            m_rank_reg <= out_item.rank;
            m_exch_reg <= out_item.exch;
            m_last_reg <= out_item.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = M_TDATA_W'({m_exch_reg, m_rank_reg, m_rec_reg.name, m_rec_reg.score});

`ifndef NO_ASSERTIONS
    a_exch_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_exch_reg <= EXCH_W'(EXCH_LIMIT))
        else $error("exchange count above pair limit");

    a_descending: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_item.load && out_item.rank != '0) |-> out_item.rec.score <= m_rec_reg.score)
        else $error("drained scores not in descending order");

    a_last_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_rank_reg == RANK_W'(ENTRIES - 1))
        else $error("last item at wrong rank");

    a_no_input_while_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        out_item.load |-> !s_tready)
        else $error("input accepted during drain");
`endif

endmodule

>>> verif/score_table_sorter_top_test.sv
// Self-checking testbench for the score table sorter: stable descending sort of 16-record batches.
module score_table_sorter_top_test;
    import stsort_pkg::*;

    localparam int NAME_LO     = SCORE_W;
    localparam int RANK_LO     = SCORE_W + NAME_W;
    localparam int EXCH_LO     = RANK_LO + RANK_W;
    localparam int PLAN_ROWS   = 25;
    localparam int RAND_ITEMS  = 151;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [NAME_W-1:0]  name;
        logic [RANK_W-1:0]  rank;
        logic [EXCH_W-1:0]  exch;
        logic               last;
    } ranked_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [NAME_W-1:0]  name;
        logic               known;
        logic [SCORE_W-1:0] exp_score;
        logic [NAME_W-1:0]  exp_name;
        logic [EXCH_W-1:0]  exp_exch;
    } plan_row_t;

    typedef enum {MIX_FULL, MIX_NARROW, MIX_RISING, MIX_FALLING, MIX_FLAT} score_mix_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    rec_t              board [ENTRIES];
    int unsigned       held;
    logic [EXCH_W-1:0] swaps;
    bit                typed_batch;
    ranked_t           ranked_q [$];
    int unsigned       mismatches;
    int unsigned       results_seen;
    int unsigned       quiet_cycles;
    bit                pressure_done;

    // rows 0-15 rise, so every later record passes every earlier one: 120 exchanges; later rows repeat scores
    plan_row_t plan [PLAN_ROWS] = '{
        '{16'h0000, 56'h00000000000000, 1'b1, 16'hFFFF, 56'hFFFFFFFFFFFFFF, 7'd120},
        '{16'h0001, 56'h41414141414141, 1'b1, 16'hFFFE, 56'h7FFFFFFFFFFFFE, 7'd120},
        '{16'h0002, 56'h42424242424242, 1'b1, 16'hF000, 56'h80000000000001, 7'd120},
        '{16'h0010, 56'h43434343434343, 1'b1, 16'hC000, 56'hAA55AA55AA55AA, 7'd120},
        '{16'h0100, 56'h44444444444444, 1'b1, 16'hAAAA, 56'h55AA55AA55AA55, 7'd120},
        '{16'h0800, 56'h45454545454545, 1'b1, 16'h8000, 56'h4A4A4A4A4A4A4A, 7'd120},
        '{16'h1000, 56'h46464646464646, 1'b1, 16'h7FFF, 56'h49494949494949, 7'd120},
        '{16'h3FFF, 56'h47474747474747, 1'b1, 16'h4000, 56'h48484848484848, 7'd120},
        '{16'h4000, 56'h48484848484848, 1'b1, 16'h3FFF, 56'h47474747474747, 7'd120},
        '{16'h7FFF, 56'h49494949494949, 1'b1, 16'h1000, 56'h46464646464646, 7'd120},
        '{16'h8000, 56'h4A4A4A4A4A4A4A, 1'b1, 16'h0800, 56'h45454545454545, 7'd120},
        '{16'hAAAA, 56'h55AA55AA55AA55, 1'b1, 16'h0100, 56'h44444444444444, 7'd120},
        '{16'hC000, 56'hAA55AA55AA55AA, 1'b1, 16'h0010, 56'h43434343434343, 7'd120},
        '{16'hF000, 56'h80000000000001, 1'b1, 16'h0002, 56'h42424242424242, 7'd120},
        '{16'hFFFE, 56'h7FFFFFFFFFFFFE, 1'b1, 16'h0001, 56'h41414141414141, 7'd120},
        '{16'hFFFF, 56'hFFFFFFFFFFFFFF, 1'b1, 16'h0000, 56'h00000000000000, 7'd120},
        '{16'h8000, 56'h11111111111111, 1'b0, 16'h0000, 56'h00000000000000, 7'd0},
        '{16'h8000, 56'h22222222222222, 1'b0, 16'h0000, 56'h00000000000000, 7'd0},
        '{16'hFFFF, 56'h33333333333333, 1'b0, 16'h0000, 56'h00000000000000, 7'd0},
        '{16'h8000, 56'h44444444444444, 1'b0, 16'h0000, 56'h00000000000000, 7'd0},
        '{16'hFFFF, 56'h55555555555555, 1'b0, 16'h0000, 56'h00000000000000, 7'd0},
        '{16'h0000, 56'h66666666666666, 1'b0, 16'h0000, 56'h00000000000000, 7'd0},
        '{16'h0000, 56'h77777777777777, 1'b0, 16'h0000, 56'h00000000000000, 7'd0},
        '{16'h8000, 56'h88888888888888, 1'b0, 16'h0000, 56'h00000000000000, 7'd0},
        '{16'h0001, 56'h99999999999999, 1'b0, 16'h0000, 56'h00000000000000, 7'd0}
    };

    score_table_sorter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // insert at the tail, bubble toward the head past strictly lower scores
    function automatic void insert_record(rec_t r);
        int unsigned p;
        rec_t        t;
        p = held;
        board[p] = r;
        while (p > 0 && board[p].score > board[p-1].score) begin
            t          = board[p-1];
            board[p-1] = board[p];
            board[p]   = t;
            if (swaps != EXCH_MAX) swaps++;
            p--;
        end
        held++;
        if (held == ENTRIES) begin
            if (!typed_batch) begin
                for (int k = 0; k < ENTRIES; k++)
                    ranked_q.push_back('{board[k].score, board[k].name, k[RANK_W-1:0],
                                         swaps, k == ENTRIES - 1});
            end
            held  = 0;
            swaps = '0;
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic void flag_field(string what, logic [63:0] want, logic [63:0] seen);
        if (want !== seen) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, seen);
        end
    endfunction

    task automatic send_rec(input rec_t r, input int unsigned gap);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        do @(posedge aclk); while (!s_tready);
        insert_record(r);
    endtask

    initial begin
        rec_t        r;
        score_mix_t  mix;
        int unsigned pos;
        int unsigned base;
        int unsigned step;
        int unsigned gap;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        aresetn     = 1'b0;
        held        = 0;
        swaps       = '0;
        typed_batch = 1'b0;
        mismatches  = 0;
        mix         = MIX_FULL;
        base        = 0;
        step        = 1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < PLAN_ROWS; i++) begin
            typed_batch = plan[i].known;
            r.score     = plan[i].score;
            r.name      = plan[i].name;
            send_rec(r, pick_gap());
            if (plan[i].known)
                ranked_q.push_back('{plan[i].exp_score, plan[i].exp_name, i[RANK_W-1:0],
                                     plan[i].exp_exch, i == ENTRIES - 1});
        end
        typed_batch = 1'b0;

        for (int idx = PLAN_ROWS; idx < PLAN_ROWS + RAND_ITEMS; idx++) begin
            pos = idx % ENTRIES;
            if (pos == 0) begin
                mix  = score_mix_t'($urandom_range(0, 4));
                step = $urandom_range(1, 4000);
                case (mix)
                    MIX_RISING, MIX_FALLING: base = $urandom_range(0, 65535 - 15 * step);
                    MIX_NARROW:              base = $urandom_range(0, 65532);
                    default:                 base = $urandom_range(0, 65535);
                endcase
            end
            case (mix)
                MIX_NARROW:  r.score = SCORE_W'(base + $urandom_range(0, 3));
                MIX_RISING:  r.score = SCORE_W'(base + pos * step);
                MIX_FALLING: r.score = SCORE_W'(base + (ENTRIES - 1 - pos) * step);
                MIX_FLAT:    r.score = SCORE_W'(base);
                default: begin
                    case ($urandom_range(0, 7))
                        0:       r.score = '0;
                        1:       r.score = '1;
                        default: r.score = SCORE_W'($urandom_range(0, 65535));
                    endcase
                end
            endcase
            r.name = NAME_W'({$urandom, $urandom});
            gap    = (idx / ENTRIES == 7) ? 0 : pick_gap();
            send_rec(r, gap);
        end
        s_tvalid <= 1'b0;

        while (ranked_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0)
            $display("score_table_sorter_top_test: done, clean");
        else
            $display("score_table_sorter_top_test: done, errors");
        $finish;
    end

    // result side: random stalls, one long hold, and a stretch with none
    initial begin
        int unsigned len;
        int unsigned r;
        m_tready      = 1'b0;
        results_seen  = 0;
        pressure_done = 1'b0;
        @(posedge aclk);
        forever begin
            r   = $urandom_range(0, 99);
            len = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            if (results_seen >= 96 && results_seen < 144) len = 0;
            if (!pressure_done && results_seen >= 48) begin
                pressure_done = 1'b1;
                len           = 300;
            end
            if (len != 0) begin
                m_tready <= 1'b0;
                repeat (len) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        ranked_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (ranked_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected item, expected none, got %h", $time, m_tdata);
            end else begin
                want = ranked_q.pop_front();
                flag_field("sorted_score", 64'(want.score), 64'(m_tdata[0 +: SCORE_W]));
                flag_field("sorted_name", 64'(want.name), 64'(m_tdata[NAME_LO +: NAME_W]));
                flag_field("rank", 64'(want.rank), 64'(m_tdata[RANK_LO +: RANK_W]));
                flag_field("exchange_count", 64'(want.exch),
                           64'(m_tdata[EXCH_LO +: EXCH_W]));
                flag_field("last_out", 64'(want.last), 64'(m_tlast));
            end
        end
    end

    initial quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("score_table_sorter_top_test: done, errors");
            $finish;
        end
    end

endmodule

>>> files.f
rtl/stsort_pkg.sv
rtl/stsort_ram.sv
rtl/stsort_ctrl.sv
rtl/score_table_sorter_top.sv
verif/score_table_sorter_top_test.sv
